>>> rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants shared by the per-bucket stride detector modules.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int BUCKET_W = 10;
	localparam int BUCKET_MAX = (1 << BUCKET_W) - 1;
	localparam int PORT_W = 32;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_FIRST = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LEARNED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MATCH = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

	typedef enum logic [2:0] {
		FSM_INIT,
		FSM_IDLE,
		FSM_READ,
		FSM_EVAL,
		FSM_CLEAR
	} fsm_state_t;

	typedef struct packed {
		logic cap;
		logic rd;
		logic eval;
		logic sweep_wr;
		logic emit_clr;
	} psd_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} psd_stat_t;

endpackage

>>> rtl/psd_ram.sv
// ----------------------------------------------------------------------------
// psd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module psd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// Controller: sequences the table sweep after reset, the key lookup and
// update, and the sweep that a clear beat starts.
// ----------------------------------------------------------------------------
module psd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 kind,
	input  psd_pkg::psd_stat_t   stat,
	output psd_pkg::psd_cmd_t    cmd,
	output logic                 busy
);

	psd_pkg::fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psd_pkg::FSM_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			psd_pkg::FSM_INIT: begin
				if (stat.sweep_last) state_d = psd_pkg::FSM_IDLE;
			end
			psd_pkg::FSM_IDLE: begin
				if (start) state_d = kind ? psd_pkg::FSM_CLEAR : psd_pkg::FSM_READ;
			end
			psd_pkg::FSM_READ: state_d = psd_pkg::FSM_EVAL;
			psd_pkg::FSM_EVAL: state_d = psd_pkg::FSM_IDLE;
			psd_pkg::FSM_CLEAR: begin
				if (stat.sweep_last) state_d = psd_pkg::FSM_IDLE;
			end
			default: state_d = psd_pkg::FSM_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			psd_pkg::FSM_INIT: cmd.sweep_wr = 1'b1;
			psd_pkg::FSM_IDLE: begin
				busy = 1'b0;
				cmd.cap = start && !kind;
			end
			psd_pkg::FSM_READ: cmd.rd = 1'b1;
			psd_pkg::FSM_EVAL: cmd.eval = 1'b1;
			psd_pkg::FSM_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				cmd.emit_clr = stat.sweep_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/psd_datapath.sv
// ----------------------------------------------------------------------------
// psd_datapath
// Datapath: key capture, bucket reduction, table memory, difference and
// stride comparison, and the result register.
// ----------------------------------------------------------------------------
module psd_datapath #(
	parameter int NUM_BUCKETS = 1024,
	parameter int COORD_WIDTH = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  psd_pkg::psd_cmd_t                        cmd,
	output psd_pkg::psd_stat_t                       stat,
	input  logic [psd_pkg::BUCKET_W-1:0]             bucket,
	input  logic signed [psd_pkg::PORT_W-1:0]        coord_i,
	input  logic signed [psd_pkg::PORT_W-1:0]        coord_j,
	input  logic signed [psd_pkg::PORT_W-1:0]        coord_k,
	output logic                                     done,
	output logic [psd_pkg::STATUS_W-1:0]             status,
	output logic signed [psd_pkg::PORT_W-1:0]        delta_i,
	output logic signed [psd_pkg::PORT_W-1:0]        delta_j,
	output logic signed [psd_pkg::PORT_W-1:0]        delta_k
);

	localparam int AW = $clog2(NUM_BUCKETS);
	localparam int CW = COORD_WIDTH;
	localparam int EW = 2 + 6 * CW;

	logic [psd_pkg::BUCKET_W-1:0] bkt_red;
	logic [AW-1:0]                addr_q;
	logic [CW-1:0]                key_i_q, key_j_q, key_k_q;
	logic [AW-1:0]                sweep_cnt_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;

	logic          ent_valid, ent_known;
	logic [CW-1:0] prev_i, prev_j, prev_k;
	logic [CW-1:0] step_i, step_j, step_k;
	logic [CW-1:0] dif_i, dif_j, dif_k;
	logic          stride_eq;
	logic [psd_pkg::STATUS_W-1:0] eval_status;

	// Bucket index reduced modulo the table depth by shifted subtraction.
	always_comb begin
		bkt_red = bucket;
		for (int s = psd_pkg::BUCKET_W - 1; s >= 0; s--) begin
			if (((NUM_BUCKETS << s) <= psd_pkg::BUCKET_MAX) &&
			    (bkt_red >= psd_pkg::BUCKET_W'(NUM_BUCKETS << s))) begin
				bkt_red = bkt_red - psd_pkg::BUCKET_W'(NUM_BUCKETS << s);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			addr_q <= AW'(bkt_red);
			key_i_q <= coord_i[CW-1:0];
			key_j_q <= coord_j[CW-1:0];
			key_k_q <= coord_k[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
		end else if (cmd.sweep_wr) begin
			sweep_cnt_q <= stat.sweep_last ? '0 : sweep_cnt_q + 1'b1;
		end
	end

	assign stat.sweep_last = (sweep_cnt_q == AW'(NUM_BUCKETS - 1));

	assign ent_valid = ram_rdata[EW-1];
	assign ent_known = ram_rdata[EW-2];
	assign prev_i = ram_rdata[6*CW-1 -: CW];
	assign prev_j = ram_rdata[5*CW-1 -: CW];
	assign prev_k = ram_rdata[4*CW-1 -: CW];
	assign step_i = ram_rdata[3*CW-1 -: CW];
	assign step_j = ram_rdata[2*CW-1 -: CW];
	assign step_k = ram_rdata[CW-1 -: CW];

	assign dif_i = key_i_q - prev_i;
	assign dif_j = key_j_q - prev_j;
	assign dif_k = key_k_q - prev_k;
	assign stride_eq = (dif_i == step_i) && (dif_j == step_j) && (dif_k == step_k);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {1'b1, 1'b1, key_i_q, key_j_q, key_k_q, step_i, step_j, step_k};
		eval_status = psd_pkg::ST_MISMATCH;
		if (cmd.sweep_wr) begin
			ram_we = 1'b1;
			ram_waddr = sweep_cnt_q;
			ram_wdata = '0;
		end else if (cmd.eval) begin
			if (!ent_valid) begin
				ram_we = 1'b1;
				ram_wdata[EW-2] = 1'b0;
				eval_status = psd_pkg::ST_FIRST;
			end else if (!ent_known) begin
				ram_we = 1'b1;
				ram_wdata = {1'b1, 1'b1, key_i_q, key_j_q, key_k_q, dif_i, dif_j, dif_k};
				eval_status = psd_pkg::ST_LEARNED;
			end else if (stride_eq) begin
				ram_we = 1'b1;
				eval_status = psd_pkg::ST_MATCH;
			end
		end
	end

	psd_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_BUCKETS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.eval || cmd.emit_clr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_clr) begin
			status <= psd_pkg::ST_CLEARED;
			delta_i <= '0;
			delta_j <= '0;
			delta_k <= '0;
		end else if (cmd.eval) begin
			status <= eval_status;
			if (ent_valid) begin
				delta_i <= psd_pkg::PORT_W'($signed(dif_i));
				delta_j <= psd_pkg::PORT_W'($signed(dif_j));
				delta_k <= psd_pkg::PORT_W'($signed(dif_k));
			end else begin
				delta_i <= '0;
				delta_j <= '0;
				delta_k <= '0;
			end
		end
	end

endmodule

>>> rtl/per_bucket_stride_detector_core.sv
// ----------------------------------------------------------------------------
// per_bucket_stride_detector_core
// Learns a three-coordinate stride per bucket and reports each key as first
// seen, stride learned, stride match or mismatch; a clear beat empties the
// table.
//
//   Channel   Handshake        Signals
//   input     start & !busy    kind, bucket, coord_i, coord_j, coord_k
//   result    done (strobe)    status, delta_i, delta_j, delta_k
//
// A key beat runs through capture, table read, then evaluation with the
// table write; its result is registered after the evaluation. The table
// read is its own step because the table memory's read port is registered.
// A clear beat writes every table entry, one table entry per cycle.
// After reset the whole table is swept with busy high.
// The receiver cannot stall; every result is held for exactly one cycle.
// ----------------------------------------------------------------------------
module per_bucket_stride_detector_core #(
	parameter int NUM_BUCKETS = 1024,
	parameter int COORD_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic [psd_pkg::BUCKET_W-1:0]         bucket,
	input  logic signed [psd_pkg::PORT_W-1:0]    coord_i,
	input  logic signed [psd_pkg::PORT_W-1:0]    coord_j,
	input  logic signed [psd_pkg::PORT_W-1:0]    coord_k,
	output logic                                 done,
	output logic [psd_pkg::STATUS_W-1:0]         status,
	output logic signed [psd_pkg::PORT_W-1:0]    delta_i,
	output logic signed [psd_pkg::PORT_W-1:0]    delta_j,
	output logic signed [psd_pkg::PORT_W-1:0]    delta_k
);

	psd_pkg::psd_cmd_t  cmd;
	psd_pkg::psd_stat_t stat;

	psd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	psd_datapath #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.COORD_WIDTH(COORD_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.bucket (bucket),
		.coord_i(coord_i),
		.coord_j(coord_j),
		.coord_k(coord_k),
		.done   (done),
		.status (status),
		.delta_i(delta_i),
		.delta_j(delta_j),
		.delta_k(delta_k)
	);

endmodule

>>> rtl/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the stride detector's beat timing and results.
// ----------------------------------------------------------------------------
module psd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              kind,
	input logic                              done,
	input logic [psd_pkg::STATUS_W-1:0]      status,
	input logic signed [psd_pkg::PORT_W-1:0] delta_i,
	input logic signed [psd_pkg::PORT_W-1:0] delta_j,
	input logic signed [psd_pkg::PORT_W-1:0] delta_k
);

	// A key beat delivers its result after the table read and evaluation states that follow its acceptance.
	a_key_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !kind |-> ##3 done)
		else $error("key beat result not delivered on time");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted beat");

	a_no_double_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= psd_pkg::ST_CLEARED)
		else $error("result status out of range");

	// First-seen and cleared results carry zero differences.
	a_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == psd_pkg::ST_FIRST || status == psd_pkg::ST_CLEARED)
		|-> delta_i == 0 && delta_j == 0 && delta_k == 0)
		else $error("non-zero difference on a first-seen or cleared result");

endmodule

bind per_bucket_stride_detector_core psd_checker u_psd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.kind   (kind),
	.done   (done),
	.status (status),
	.delta_i(delta_i),
	.delta_j(delta_j),
	.delta_k(delta_k)
);
